// ----- rtl/can_tx_mailbox_priority_select_defines.svh -----
// Assertion macros for the CAN transmit mailbox priority selector.
// Taken in by the top level; the macros use the clk and rst_n of the including scope.
`ifndef CAN_TX_MAILBOX_PRIORITY_SELECT_DEFINES_SVH
`define CAN_TX_MAILBOX_PRIORITY_SELECT_DEFINES_SVH

// Check that is switched off while reset is held.
`define CTMPS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also applies across reset.
`define CTMPS_CHECK_RAW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ctmps_pkg.sv -----
// Shared types, constants and the arbitration field function for the
// CAN transmit mailbox priority selector. No dependencies.
package ctmps_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int ID_W      = 29;
  localparam int HDR_W     = 32;
  localparam int ARB_W     = 32;
  localparam int CNT_W     = $clog2(ARB_W);

  localparam int HDR_EXT_BIT = 29;
  localparam int HDR_FD_BIT  = 30;
  localparam int HDR_BRS_BIT = 31;
  localparam int STD_ID_W    = 11;
  localparam int STD_SHIFT   = 21;

  localparam logic [ARB_W-1:0] EXT_MARK = 32'h0020_0000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CANCEL = 2'd1,
    OP_SELECT = 2'd2,
    OP_DONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INACTIVE = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK
  } fsm_t;

  // Control from the sequencer to the lanes and the top level.
  typedef struct packed {
    logic load;
    logic shift;
    logic pick;
    logic busy;
  } scan_ctl_t;

  // Packed arbitration field of a stored header {brs, fd, ext, id}.
  function automatic logic [ARB_W-1:0] arb_of(input logic [HDR_W-1:0] hdr);
    logic [ARB_W-1:0] f;
    if (hdr[HDR_EXT_BIT]) begin
      f = {hdr[ID_W-1:0], 3'b000} | EXT_MARK;
    end else begin
      f = {hdr[STD_ID_W-1:0], {STD_SHIFT{1'b0}}};
    end
    f[1] = f[1] | hdr[HDR_FD_BIT];
    f[0] = f[0] | hdr[HDR_BRS_BIT];
    return f;
  endfunction

endpackage

// ----- rtl/can_tx_mailbox_priority_select.sv -----
// Top level of the CAN transmit mailbox bank with priority selection.
// Depends on ctmps_pkg, ctmps_lane, ctmps_ctrl and the assertion macro header.
`include "can_tx_mailbox_priority_select_defines.svh"

// A command is transferred at a rising edge where start is high and busy is
// low. Its result appears on the out_ ports for exactly one cycle, marked by
// out_valid; the receiver cannot stall it, so it must take the result in that
// cycle. Load, cancel, done and a select that finds no pending mailbox keep
// busy low and give their result in the cycle after the transfer, and a new
// command can be transferred in the cycle right after. A select with pending
// mailboxes keeps busy high through the scan and pick states and delivers its
// result after the pick: every lane shifts its 32-bit arbitration field out one bit per cycle, most
// significant first, and drops out when it shows a one while another live
// lane shows a zero, the same wired-AND rule as arbitration on the bus. The
// field width sets the length of the scan. Among lanes still live at the end, which
// carry equal fields, the highest slot number wins and becomes the current
// transmission. Fields of a result that do not apply to its command are zero.
module can_tx_mailbox_priority_select import ctmps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_slot,
  input  logic [28:0] in_msg_id,
  input  logic        in_is_extended,
  input  logic        in_fd_frame,
  input  logic        in_bit_rate_switch,
  input  logic        in_acked,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [2:0]  out_win_slot,
  output logic [31:0] out_arb_field,
  output logic [28:0] out_win_id,
  output logic        out_win_extended,
  output logic        out_win_fd,
  output logic        out_win_brs,
  output logic        out_sent_done
);

  // Mailbox state: valid bits, stored headers and the current transmission.
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [HDR_W-1:0]     hdr_r [NUM_SLOTS];
  logic [SLOT_W-1:0]    cur_r, cur_nxt;

  // Result registers.
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [SLOT_W-1:0] win_slot_r, win_slot_nxt;
  logic [ARB_W-1:0]  arb_r, arb_nxt;
  logic [HDR_W-1:0]  win_hdr_r, win_hdr_nxt;
  logic              sent_r, sent_nxt;

  scan_ctl_t            ctl;
  logic                 accept;
  op_t                  op;
  logic                 slot_ok;
  logic                 sel_go;
  logic [NUM_SLOTS-1:0] alive;
  logic [NUM_SLOTS-1:0] zero_req;
  logic                 any_zero;
  logic [SLOT_W-1:0]    win_idx;
  logic [HDR_W-1:0]     load_hdr;

  assign busy     = ctl.busy;
  assign accept   = start & ~busy;
  assign op       = op_t'(in_operation);
  assign slot_ok  = int'(in_slot) < NUM_SLOTS;
  assign sel_go   = accept && (op == OP_SELECT) && (|valid_r);
  assign any_zero = |zero_req;
  assign load_hdr = {in_bit_rate_switch, in_fd_frame, in_is_extended, in_msg_id};

  ctmps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .sel_go (sel_go),
    .ctl    (ctl)
  );

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
    ctmps_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .hdr        (hdr_r[g]),
      .slot_valid (valid_r[g]),
      .any_zero   (any_zero),
      .alive      (alive[g]),
      .zero_req   (zero_req[g])
    );
  end

  // The survivors hold equal fields; the highest slot number among them wins.
  always_comb begin
    win_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (alive[i]) begin
        win_idx = SLOT_W'(i);
      end
    end
  end

  // Mailbox bookkeeping and the result of each command.
  always_comb begin
    valid_nxt     = valid_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    win_slot_nxt  = win_slot_r;
    arb_nxt       = arb_r;
    win_hdr_nxt   = win_hdr_r;
    sent_nxt      = sent_r;

    if (accept) begin
      status_nxt   = STAT_OK;
      win_slot_nxt = '0;
      arb_nxt      = '0;
      win_hdr_nxt  = '0;
      sent_nxt     = 1'b0;
      case (op)
        OP_LOAD: begin
          out_valid_nxt = 1'b1;
          if (slot_ok) begin
            valid_nxt[in_slot] = 1'b1;
          end
        end
        OP_CANCEL: begin
          out_valid_nxt = 1'b1;
          if (slot_ok && valid_r[in_slot]) begin
            valid_nxt[in_slot] = 1'b0;
          end else begin
            status_nxt = STAT_INACTIVE;
          end
        end
        OP_SELECT: begin
          // With pending mailboxes the result comes from the scan.
          if (!(|valid_r)) begin
            out_valid_nxt = 1'b1;
            status_nxt    = STAT_EMPTY;
          end
        end
        OP_DONE: begin
          out_valid_nxt = 1'b1;
          win_slot_nxt  = cur_r;
          if (in_acked && valid_r[cur_r]) begin
            valid_nxt[cur_r] = 1'b0;
            sent_nxt         = 1'b1;
          end
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end else if (ctl.pick) begin
      out_valid_nxt = 1'b1;
      cur_nxt       = win_idx;
      status_nxt    = STAT_OK;
      win_slot_nxt  = win_idx;
      arb_nxt       = arb_of(hdr_r[win_idx]);
      win_hdr_nxt   = hdr_r[win_idx];
      sent_nxt      = 1'b0;
    end
  end

  // Headers are only read while their slot is valid, so they need no reset.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_LOAD) && slot_ok) begin
      hdr_r[in_slot] <= load_hdr;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    win_slot_r <= win_slot_nxt;
    arb_r      <= arb_nxt;
    win_hdr_r  <= win_hdr_nxt;
    sent_r     <= sent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_win_slot     = win_slot_r;
  assign out_arb_field    = arb_r;
  assign out_win_id       = win_hdr_r[ID_W-1:0];
  assign out_win_extended = win_hdr_r[HDR_EXT_BIT];
  assign out_win_fd       = win_hdr_r[HDR_FD_BIT];
  assign out_win_brs      = win_hdr_r[HDR_BRS_BIT];
  assign out_sent_done    = sent_r;

  // A result is only ever presented once the sequencer has returned to idle.
  `CTMPS_CHECK(a_result_when_idle, out_valid |-> !busy, "result presented while busy")
  // Elimination can never remove the last live lane during a scan.
  `CTMPS_CHECK(a_scan_keeps_winner, ctl.shift |-> (alive != '0), "scan lost every lane")
  // Every transferred command either delivers a result or starts a scan.
  `CTMPS_CHECK(a_command_progress, accept |=> (out_valid || busy), "command dropped")
  // Reset leaves the block idle with no result pending.
  `CTMPS_CHECK_RAW(a_reset_quiet, !rst_n |=> (!out_valid && !busy), "not idle after reset")

endmodule

// ----- rtl/ctmps_lane.sv -----
// One mailbox lane: shifts its arbitration field out MSB first and drops out
// of the running once another live lane shows a dominant zero. Uses ctmps_pkg.
module ctmps_lane import ctmps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_ctl_t        ctl,
  input  logic [HDR_W-1:0] hdr,
  input  logic             slot_valid,
  input  logic             any_zero,
  output logic             alive,
  output logic             zero_req
);

  logic [ARB_W-1:0] sh_r, sh_nxt;
  logic             alive_r, alive_nxt;

  always_comb begin
    sh_nxt    = sh_r;
    alive_nxt = alive_r;
    if (ctl.load) begin
      sh_nxt    = arb_of(hdr);
      alive_nxt = slot_valid;
    end else if (ctl.shift) begin
      sh_nxt = {sh_r[ARB_W-2:0], 1'b0};
      // A recessive one loses against any live dominant zero.
      if (any_zero && sh_r[ARB_W-1]) begin
        alive_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
    end else begin
      alive_r <= alive_nxt;
    end
  end

  assign alive    = alive_r;
  assign zero_req = alive_r & ~sh_r[ARB_W-1];

endmodule

// ----- rtl/ctmps_ctrl.sv -----
// Sequencer for the bit-serial select: load, one cycle per field bit, pick.
// Uses ctmps_pkg.
module ctmps_ctrl import ctmps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      sel_go,
  output scan_ctl_t ctl
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ARB_W - 1);

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (sel_go) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: ctl.load = sel_go;
      S_SCAN: begin
        ctl.shift = 1'b1;
        ctl.busy  = 1'b1;
      end
      S_PICK: begin
        ctl.pick = 1'b1;
        ctl.busy = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- tb/can_tx_mailbox_priority_select_tb.sv -----
// Self-checking testbench for the CAN transmit mailbox priority selector.
// Depends on ctmps_pkg (slot count, operation and status codes) and the RTL top level only.
module can_tx_mailbox_priority_select_tb import ctmps_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // One command as it is presented on the in_ ports.
  typedef struct {
    op_t         operation;
    logic [2:0]  slot;
    logic [28:0] msg_id;
    logic        ext;
    logic        fd;
    logic        brs;
    logic        acked;
  } mailbox_cmd_t;

  // One result as it appears on the out_ ports.
  typedef struct {
    logic [1:0]  status;
    logic [2:0]  win_slot;
    logic [31:0] arb_field;
    logic [28:0] win_id;
    logic        win_extended;
    logic        win_fd;
    logic        win_brs;
    logic        sent_done;
  } mailbox_result_t;

  // The scoreboard keeps its own copy of the mailbox bank. Every transferred
  // command is applied to that copy at once, and the result it must produce
  // is queued; results from the block are matched in order against the queue.
  class mailbox_scoreboard;
    bit              live[NUM_SLOTS];
    logic [28:0]     ids[NUM_SLOTS];
    bit              ext_f[NUM_SLOTS];
    bit              fd_f[NUM_SLOTS];
    bit              brs_f[NUM_SLOTS];
    logic [2:0]      on_air;
    mailbox_result_t pending_q[$];
    int              errors;
    int              commands;
    int              checked;
    int              winners;
    int              empty_selects;
    int              rejected_cancels;
    int              sent_count;

    function new();
      foreach (live[s]) begin
        live[s] = 1'b0;
      end
      on_air = '0;
    endfunction

    // Packed field that decides bus priority; lower wins.
    function logic [31:0] frame_priority(int s);
      logic [31:0] f;
      if (ext_f[s]) begin
        f = {ids[s], 3'b000};
        f[21] = 1'b1;
      end else begin
        f = {ids[s][10:0], 21'd0};
      end
      f[1] = f[1] | fd_f[s];
      f[0] = f[0] | brs_f[s];
      return f;
    endfunction

    function void note_command(mailbox_cmd_t c);
      mailbox_result_t r;
      logic [31:0]     best;
      int              best_slot;
      r = '{default: '0};
      r.status = STAT_OK;
      commands++;
      case (c.operation)
        OP_LOAD: begin
          ids[c.slot]   = c.msg_id;
          ext_f[c.slot] = c.ext;
          fd_f[c.slot]  = c.fd;
          brs_f[c.slot] = c.brs;
          live[c.slot]  = 1'b1;
        end
        OP_CANCEL: begin
          if (live[c.slot]) begin
            live[c.slot] = 1'b0;
          end else begin
            r.status = STAT_INACTIVE;
            rejected_cancels++;
          end
        end
        OP_SELECT: begin
          best_slot = -1;
          best = '0;
          // Scanning upward with <= lets the highest slot win a tie.
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (live[s] && (best_slot < 0 || frame_priority(s) <= best)) begin
              best = frame_priority(s);
              best_slot = s;
            end
          end
          if (best_slot < 0) begin
            r.status = STAT_EMPTY;
            empty_selects++;
          end else begin
            on_air         = best_slot[2:0];
            r.win_slot     = on_air;
            r.arb_field    = best;
            r.win_id       = ids[best_slot];
            r.win_extended = ext_f[best_slot];
            r.win_fd       = fd_f[best_slot];
            r.win_brs      = brs_f[best_slot];
            winners++;
          end
        end
        default: begin
          r.win_slot = on_air;
          if (c.acked && live[on_air]) begin
            live[on_air] = 1'b0;
            r.sent_done = 1'b1;
            sent_count++;
          end
        end
      endcase
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(mailbox_result_t got);
      mailbox_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with no command waiting, status %h slot %h arb %h",
                 $time, got.status, got.win_slot, got.arb_field);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("win_slot", 32'(want.win_slot), 32'(got.win_slot));
      compare_field("arb_field", want.arb_field, got.arb_field);
      compare_field("win_id", 32'(want.win_id), 32'(got.win_id));
      compare_field("win_extended", 32'(want.win_extended), 32'(got.win_extended));
      compare_field("win_fd", 32'(want.win_fd), 32'(got.win_fd));
      compare_field("win_brs", 32'(want.win_brs), 32'(got.win_brs));
      compare_field("sent_done", 32'(want.sent_done), 32'(got.sent_done));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [2:0]  in_slot;
  logic [28:0] in_msg_id;
  logic        in_is_extended;
  logic        in_fd_frame;
  logic        in_bit_rate_switch;
  logic        in_acked;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [2:0]  out_win_slot;
  logic [31:0] out_arb_field;
  logic [28:0] out_win_id;
  logic        out_win_extended;
  logic        out_win_fd;
  logic        out_win_brs;
  logic        out_sent_done;

  mailbox_scoreboard sb;

  can_tx_mailbox_priority_select DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_slot            (in_slot),
    .in_msg_id          (in_msg_id),
    .in_is_extended     (in_is_extended),
    .in_fd_frame        (in_fd_frame),
    .in_bit_rate_switch (in_bit_rate_switch),
    .in_acked           (in_acked),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_win_slot       (out_win_slot),
    .out_arb_field      (out_arb_field),
    .out_win_id         (out_win_id),
    .out_win_extended   (out_win_extended),
    .out_win_fd         (out_win_fd),
    .out_win_brs        (out_win_brs),
    .out_sent_done      (out_sent_done)
  );

  // 12 ns clock period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The result channel cannot be stalled, so every cycle with out_valid high
  // is one result transfer. It is sampled at the rising edge that closes it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{out_status, out_win_slot, out_arb_field, out_win_id,
                        out_win_extended, out_win_fd, out_win_brs, out_sent_done});
    end
  end

  // Present one command from a falling edge and hold it until a rising edge
  // sees busy low, which is the command transfer. The task returns at the next
  // falling edge with start still high, so a following command can go out
  // back to back without start dropping in between.
  task automatic issue(input op_t op, input logic [2:0] slot, input logic [28:0] id,
                       input logic ext, input logic fd, input logic brs,
                       input logic ack);
    in_operation       <= op;
    in_slot            <= slot;
    in_msg_id          <= id;
    in_is_extended     <= ext;
    in_fd_frame        <= fd;
    in_bit_rate_switch <= brs;
    in_acked           <= ack;
    start              <= 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sb.note_command('{op, slot, id, ext, fd, brs, ack});
    @(negedge clk);
  endtask

  // Random idle cycles ahead of a command, idle_pct percent per cycle.
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Hold the sender off until every queued result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // One random command. Loads dominate so that the bank fills up and selects
  // see real contention; a share of identifiers is crowded into a few values
  // near both ends of the range so that close races and exact ties happen,
  // a share is limited to 11 bits, and the rest are fully random, which also
  // puts junk in the upper bits of standard identifiers.
  task automatic random_command();
    logic [31:0] r;
    logic [31:0] id_bits;
    int          pick;
    op_t         op;
    pick = $urandom_range(99);
    r = $urandom;
    id_bits = $urandom;
    if (pick < 40) begin
      op = OP_LOAD;
    end else if (pick < 55) begin
      op = OP_CANCEL;
    end else if (pick < 80) begin
      op = OP_SELECT;
    end else begin
      op = OP_DONE;
    end
    case (r[9:8])
      2'd0: id_bits = {28'd0, id_bits[3:0]};
      2'd1: id_bits = {3'd0, 25'h1FF_FFFF, id_bits[3:0]};
      2'd2: id_bits = {21'd0, id_bits[10:0]};
      default: ;
    endcase
    issue(op, r[2:0], id_bits[28:0], r[3], r[4], r[5], r[7:6] != 2'b00);
  endtask

  // Watchdog: far beyond the slowest legal run of about 1800 commands, even
  // with every command a select with a full scan behind the longest sender gaps.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int idle_pct[3];
    idle_pct[0] = 25;
    idle_pct[1] = 84;
    idle_pct[2] = 0;
    sb = new();

    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_operation       <= OP_LOAD;
    in_slot            <= '0;
    in_msg_id          <= '0;
    in_is_extended     <= 1'b0;
    in_fd_frame        <= 1'b0;
    in_bit_rate_switch <= 1'b0;
    in_acked           <= 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. An empty bank: select finds nothing, done with an
    // acknowledge has nothing to remove, and a cancel hits an inactive slot.
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_DONE, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    issue(OP_CANCEL, 3'd5, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Extremes: all-ones extended identifier with both flags (the shift
    // puts id bit 28 at bit 31), all-ones standard identifier with junk above bit
    // 10, extended zero, and a standard zero that gives the lowest field.
    issue(OP_LOAD, 3'd0, 29'h1FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    issue(OP_LOAD, 3'd7, 29'h1FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_LOAD, 3'd3, 29'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    issue(OP_LOAD, 3'd4, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // An equal field in a higher slot takes over the tie.
    issue(OP_LOAD, 3'd6, 29'h1FFF_F800, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Done without an acknowledge keeps the frame; with one it removes it.
    issue(OP_DONE, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_DONE, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Cancel the current frame, then a done on it must not report a send,
    // and a second cancel of it is rejected.
    issue(OP_CANCEL, 3'd4, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_DONE, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    issue(OP_CANCEL, 3'd4, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // An extended zero in a lower slot ties a standard identifier 1 in a
    // higher slot; the slot overwritten here is valid and current.
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_LOAD, 3'd1, 29'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    issue(OP_LOAD, 3'd3, 29'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    // The FD and BRS bits alone decide between otherwise equal frames.
    issue(OP_LOAD, 3'd2, 29'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    issue(OP_LOAD, 3'd5, 29'd0, 1'b1, 1'b0, 1'b1, 1'b0);
    issue(OP_CANCEL, 3'd1, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_CANCEL, 3'd3, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    issue(OP_SELECT, 3'd0, 29'd0, 1'b0, 1'b0, 1'b0, 1'b0);

    // Random part in three phases of sender idling. Before each phase the
    // sender waits until every outstanding result has been transferred.
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      for (int n = 0; n < 600; n++) begin
        sender_gap(idle_pct[phase]);
        random_command();
      end
    end

    // Let the last results come back, then a margin longer than a select.
    wait_drained();
    repeat (40) @(negedge clk);

    sb.errors += sb.pending_q.size();
    $display("Ran %0d commands and checked %0d results: %0d selects with a winner,",
             sb.commands, sb.checked, sb.winners);
    $display("%0d empty selects, %0d rejected cancels and %0d sent notifications.",
             sb.empty_selects, sb.rejected_cancels, sb.sent_count);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ctmps_pkg.sv
rtl/ctmps_lane.sv
rtl/ctmps_ctrl.sv
rtl/can_tx_mailbox_priority_select.sv
tb/can_tx_mailbox_priority_select_tb.sv
